### hw/rtl/bpst_pkg.sv
// ----------------------------------------------------------------------------
// bpst_pkg
// Shared widths, queue word type and residue table builder for the bounded
// perfect-square test unit.
// ----------------------------------------------------------------------------
package bpst_pkg;

   localparam int VALUE_BITS = 60;
   localparam int BOUND_BITS = 30;
   localparam logic [BOUND_BITS-1:0] BOUND_RESET = BOUND_BITS'(1200);

   localparam int SQ_BITS  = (VALUE_BITS + 1) / 2;
   localparam int PAD_BITS = 2 * SQ_BITS;
   localparam int REM_BITS = SQ_BITS + 1;
   localparam int CMP_BITS = (SQ_BITS > BOUND_BITS) ? SQ_BITS : BOUND_BITS;

   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   localparam int TAB_BITS = 8;
   localparam int TAB_SIZE = 1 << TAB_BITS;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  filter_ok;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Bit i set when (i mod m) is a square modulo m.
   function automatic logic [TAB_SIZE-1:0] qr_table(input int m);
      logic [TAB_SIZE-1:0] sq_flag;
      logic [TAB_SIZE-1:0] tab;
      int                  s;
      int                  r;
      sq_flag = '0;
      tab     = '0;
      s       = 0;
      r       = 0;
      for (int x = 0; x < m; x++) begin
         sq_flag[s] = 1'b1;
         s = s + 2 * x + 1;
         if (s >= m) s = s - m;
         if (s >= m) s = s - m;
      end
      for (int i = 0; i < TAB_SIZE; i++) begin
         tab[i] = sq_flag[r];
         r = r + 1;
         if (r == m) r = 0;
      end
      return tab;
   endfunction

endpackage

### hw/rtl/bpst_front.sv
// ----------------------------------------------------------------------------
// bpst_front
// Accepts words and runs the quadratic-residue filter (moduli 64, 63, 65 and
// 187 as 11 times 17) over two stages, then pushes into the queue.
// ----------------------------------------------------------------------------
module bpst_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bpst_pkg::VALUE_BITS-1:0]   req_value,
   input  bpst_pkg::qstat_type               qstat,
   output logic                              q_push,
   output bpst_pkg::item_type                q_item
);

   localparam int VB = bpst_pkg::VALUE_BITS;
   localparam int TB = bpst_pkg::TAB_BITS;

   // modulo 63 and 65 on 6-bit digits
   localparam int N6        = (VB + 5) / 6;
   localparam int W6        = 6 * N6;
   localparam int E6        = (N6 + 1) / 2;
   localparam int O6        = N6 / 2;
   localparam int S63_BITS  = $clog2(N6 * 63 + 1);
   localparam int OFF65     = 65 * ((O6 * 63 + 64) / 65);
   localparam int D65_MAX   = E6 * 63 + OFF65;
   localparam int D65_BITS  = $clog2(D65_MAX + 1);
   localparam int FIX65     = 65 * ((D65_MAX / 64 + 64) / 65);
   // modulo 11 on 5-bit digits
   localparam int N5        = (VB + 4) / 5;
   localparam int W5        = 5 * N5;
   localparam int E5        = (N5 + 1) / 2;
   localparam int O5        = N5 / 2;
   localparam int OFF11     = 11 * ((O5 * 31 + 10) / 11);
   localparam int D11_MAX   = E5 * 31 + OFF11;
   localparam int D11_BITS  = $clog2(D11_MAX + 1);
   localparam int FIX11     = 11 * ((D11_MAX / 32 + 10) / 11);
   // modulo 17 on 4-bit digits
   localparam int N4        = (VB + 3) / 4;
   localparam int W4        = 4 * N4;
   localparam int E4        = (N4 + 1) / 2;
   localparam int O4        = N4 / 2;
   localparam int OFF17     = 17 * ((O4 * 15 + 16) / 17);
   localparam int D17_MAX   = E4 * 15 + OFF17;
   localparam int D17_BITS  = $clog2(D17_MAX + 1);
   localparam int FIX17     = 17 * ((D17_MAX / 16 + 16) / 17);

   localparam logic [bpst_pkg::TAB_SIZE-1:0] QT64 = bpst_pkg::qr_table(64);
   localparam logic [bpst_pkg::TAB_SIZE-1:0] QT63 = bpst_pkg::qr_table(63);
   localparam logic [bpst_pkg::TAB_SIZE-1:0] QT65 = bpst_pkg::qr_table(65);
   localparam logic [bpst_pkg::TAB_SIZE-1:0] QT11 = bpst_pkg::qr_table(11);
   localparam logic [bpst_pkg::TAB_SIZE-1:0] QT17 = bpst_pkg::qr_table(17);

   logic                 front_adv;
   logic                 f1_valid_ff;
   logic [VB-1:0]        f1_value_ff;
   logic                 f2_valid_ff;
   logic [VB-1:0]        f2_value_ff;
   logic [5:0]           f2_low_ff;
   logic [5:0]           f2_low_in;
   logic [S63_BITS-1:0]  f2_s63_ff;
   logic [S63_BITS-1:0]  f2_s63_in;
   logic [D65_BITS-1:0]  f2_d65_ff;
   logic [D65_BITS-1:0]  f2_d65_in;
   logic [D11_BITS-1:0]  f2_d11_ff;
   logic [D11_BITS-1:0]  f2_d11_in;
   logic [D17_BITS-1:0]  f2_d17_ff;
   logic [D17_BITS-1:0]  f2_d17_in;

   logic [W6-1:0]        pad6;
   logic [W5-1:0]        pad5;
   logic [W4-1:0]        pad4;
   logic [D65_BITS-1:0]  p65, q65;
   logic [D11_BITS-1:0]  p11, q11;
   logic [D17_BITS-1:0]  p17, q17;
   logic [TB-1:0]        idx64, idx63, idx65, idx11, idx17;

   assign front_adv = !f2_valid_ff || !qstat.full;
   assign req_ready = front_adv;
   assign q_push    = f2_valid_ff && !qstat.full;

   // digit sums, alternating where the radix is minus one
   always_comb begin
      pad6      = W6'(f1_value_ff);
      pad5      = W5'(f1_value_ff);
      pad4      = W4'(f1_value_ff);
      f2_s63_in = '0;
      p65       = '0;
      q65       = '0;
      p11       = '0;
      q11       = '0;
      p17       = '0;
      q17       = '0;
      for (int c = 0; c < N6; c++) begin
         f2_s63_in = f2_s63_in + S63_BITS'(pad6[c*6 +: 6]);
      end
      for (int c = 0; c < N6; c += 2) p65 = p65 + D65_BITS'(pad6[c*6 +: 6]);
      for (int c = 1; c < N6; c += 2) q65 = q65 + D65_BITS'(pad6[c*6 +: 6]);
      for (int c = 0; c < N5; c += 2) p11 = p11 + D11_BITS'(pad5[c*5 +: 5]);
      for (int c = 1; c < N5; c += 2) q11 = q11 + D11_BITS'(pad5[c*5 +: 5]);
      for (int c = 0; c < N4; c += 2) p17 = p17 + D17_BITS'(pad4[c*4 +: 4]);
      for (int c = 1; c < N4; c += 2) q17 = q17 + D17_BITS'(pad4[c*4 +: 4]);
      f2_d65_in = p65 + D65_BITS'(OFF65) - q65;
      f2_d11_in = p11 + D11_BITS'(OFF11) - q11;
      f2_d17_in = p17 + D17_BITS'(OFF17) - q17;
      f2_low_in = pad6[5:0];
   end

   // fold once more and look up
   always_comb begin
      idx64 = TB'(f2_low_ff);
      idx63 = TB'(f2_s63_ff[5:0]) + TB'(f2_s63_ff >> 6);
      idx65 = TB'(f2_d65_ff[5:0]) + TB'(FIX65) - TB'(f2_d65_ff >> 6);
      idx11 = TB'(f2_d11_ff[4:0]) + TB'(FIX11) - TB'(f2_d11_ff >> 5);
      idx17 = TB'(f2_d17_ff[3:0]) + TB'(FIX17) - TB'(f2_d17_ff >> 4);
      q_item.value     = f2_value_ff;
      q_item.filter_ok = QT64[idx64] & QT63[idx63] & QT65[idx65]
                         & QT11[idx11] & QT17[idx17];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         f1_value_ff <= req_value;
         f2_value_ff <= f1_value_ff;
         f2_low_ff   <= f2_low_in;
         f2_s63_ff   <= f2_s63_in;
         f2_d65_ff   <= f2_d65_in;
         f2_d11_ff   <= f2_d11_in;
         f2_d17_ff   <= f2_d17_in;
      end
   end

endmodule

### hw/rtl/bpst_queue.sv
// ----------------------------------------------------------------------------
// bpst_queue
// Short FIFO of filtered words between the filter front and the root back.
// ----------------------------------------------------------------------------
module bpst_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bpst_pkg::item_type   push_item,
   input  logic                 pop,
   output bpst_pkg::item_type   head_item,
   output bpst_pkg::qstat_type  qstat
);

   localparam int PW = bpst_pkg::QPTR_BITS;
   localparam int CW = bpst_pkg::QCNT_BITS;

   bpst_pkg::item_type mem_ff [bpst_pkg::QDEPTH];
   logic [PW-1:0]      wr_ptr_ff;
   logic [PW-1:0]      rd_ptr_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;

   assign count_in    = count_ff + CW'(push) - CW'(pop);
   assign qstat.full  = (count_ff == CW'(bpst_pkg::QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_item   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/bpst_root.sv
// ----------------------------------------------------------------------------
// bpst_root
// Pipelined digit-by-digit square root, one root bit per stage, followed by
// the exactness and bound check and the result register.
// ----------------------------------------------------------------------------
module bpst_root (
   input  logic                              clock,
   input  logic                              reset,
   input  bpst_pkg::item_type                head_item,
   input  bpst_pkg::qstat_type               qstat,
   output logic                              pop,
   input  logic [bpst_pkg::BOUND_BITS-1:0]   root_bound,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_filter_ok,
   output logic                              rsp_is_square,
   output logic [bpst_pkg::BOUND_BITS-1:0]   rsp_root
);

   localparam int SQ = bpst_pkg::SQ_BITS;
   localparam int PB = bpst_pkg::PAD_BITS;
   localparam int RB = bpst_pkg::REM_BITS;
   localparam int BB = bpst_pkg::BOUND_BITS;
   localparam int CB = bpst_pkg::CMP_BITS;

   logic            adv;
   logic [SQ-1:0]   vld_ff, vld_in;
   logic [SQ-1:0]   pass_ff, pass_in;
   logic [PB-1:0]   val_ff  [SQ];
   logic [PB-1:0]   val_in  [SQ];
   logic [RB-1:0]   rem_ff  [SQ];
   logic [RB-1:0]   rem_in  [SQ];
   logic [RB-1:0]   rem_src [SQ];
   logic [SQ-1:0]   root_ff [SQ];
   logic [SQ-1:0]   root_in [SQ];
   logic [SQ-1:0]   root_src[SQ];
   logic [RB+1:0]   rem_t   [SQ];
   logic [RB+1:0]   trial   [SQ];

   logic            rsp_valid_ff;
   logic            rsp_pass_ff;
   logic            rsp_square_ff, rsp_square_in;
   logic [BB-1:0]   rsp_root_ff, rsp_root_in;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !qstat.empty;

   // stage inputs
   always_comb begin
      vld_in[0]   = !qstat.empty;
      pass_in[0]  = head_item.filter_ok;
      val_in[0]   = PB'(head_item.value);
      rem_src[0]  = '0;
      root_src[0] = '0;
      for (int s = 1; s < SQ; s++) begin
         vld_in[s]   = vld_ff[s-1];
         pass_in[s]  = pass_ff[s-1];
         val_in[s]   = val_ff[s-1];
         rem_src[s]  = rem_ff[s-1];
         root_src[s] = root_ff[s-1];
      end
   end

   // one root bit per stage, most significant pair first
   always_comb begin
      for (int s = 0; s < SQ; s++) begin
         rem_t[s] = {rem_src[s], val_in[s][2*(SQ-1-s) +: 2]};
         trial[s] = (RB+2)'({root_src[s], 2'b01});
         if (rem_t[s] >= trial[s]) begin
            rem_in[s]  = RB'(rem_t[s] - trial[s]);
            root_in[s] = SQ'({root_src[s], 1'b1});
         end else begin
            rem_in[s]  = RB'(rem_t[s]);
            root_in[s] = SQ'({root_src[s], 1'b0});
         end
      end
   end

   always_comb begin
      rsp_square_in = (rem_ff[SQ-1] == '0)
                      && (CB'(root_ff[SQ-1]) <= CB'(root_bound));
      rsp_root_in   = rsp_square_in ? BB'(root_ff[SQ-1]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[SQ-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pass_ff <= pass_in;
         for (int s = 0; s < SQ; s++) begin
            val_ff[s]  <= val_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
         rsp_pass_ff   <= pass_ff[SQ-1];
         rsp_square_ff <= rsp_square_in;
         rsp_root_ff   <= rsp_root_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filter_ok = rsp_pass_ff;
   assign rsp_is_square = rsp_square_ff;
   assign rsp_root      = rsp_root_ff;

endmodule

### hw/rtl/bounded_perfect_square_test_unit.sv
// ----------------------------------------------------------------------------
// bounded_perfect_square_test_unit
// Quadratic-residue filter and exact square root with a root bound.
//
//   Channel   Ports                              Handshake
//   request   req_valid req_ready req_value      valid/ready
//   response  rsp_valid rsp_ready rsp_filter_ok rsp_is_square rsp_root
//                                                valid/ready
//   csr       csr_write_enable csr_write_data    write on enable, no wait
//
// One word per cycle sustained while rsp_ready stays high. A word accepted
// passes the first and second filter stages, the queue write, one root
// stage per root bit and the result register before it shows on the response.
// Reset clears all valid bits and the queue and loads the bound with 1200.
// A stalled response freezes the root pipeline; the filter front keeps
// taking words until the four-word queue fills.
// ----------------------------------------------------------------------------
module bounded_perfect_square_test_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bpst_pkg::VALUE_BITS-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_filter_ok,
   output logic                              rsp_is_square,
   output logic [bpst_pkg::BOUND_BITS-1:0]   rsp_root,
   input  logic                              csr_write_enable,
   input  logic [bpst_pkg::BOUND_BITS-1:0]   csr_write_data
);

   logic [bpst_pkg::BOUND_BITS-1:0] csr_bound_ff;
   logic                            q_push;
   logic                            q_pop;
   bpst_pkg::item_type              q_in_item;
   bpst_pkg::item_type              q_head_item;
   bpst_pkg::qstat_type             qstat;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_bound_ff <= bpst_pkg::BOUND_RESET;
      end else if (csr_write_enable) begin
         csr_bound_ff <= csr_write_data;
      end
   end

   bpst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .qstat     (qstat),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   bpst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .qstat     (qstat)
   );

   bpst_root u_root (
      .clock         (clock),
      .reset         (reset),
      .head_item     (q_head_item),
      .qstat         (qstat),
      .pop           (q_pop),
      .root_bound    (csr_bound_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filter_ok (rsp_filter_ok),
      .rsp_is_square (rsp_is_square),
      .rsp_root      (rsp_root)
   );

   a_square_passes_filter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_square |-> rsp_filter_ok)
      else $error("square word failed residue filter");

   a_root_zero_when_not_square: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_square |-> rsp_root == '0)
      else $error("root not cleared for non-square word");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !q_push)
      else $error("push into full queue");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

### tb/bounded_perfect_square_test_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_perfect_square_test_unit_checker
// Watches the request, response and csr ports of the square test unit. For
// every request word it works out the residue verdict, the exact root and the
// bound decision, queues the verdict, and compares each response word field
// by field with the oldest queued verdict. Counts failures for the top.
// ----------------------------------------------------------------------------
module bounded_perfect_square_test_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [bpst_pkg::VALUE_BITS-1:0] req_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_filter_ok,
   input  logic                            rsp_is_square,
   input  logic [bpst_pkg::BOUND_BITS-1:0] rsp_root,
   input  logic                            csr_write_enable,
   input  logic [bpst_pkg::BOUND_BITS-1:0] csr_write_data,
   output int                              fail_count,
   output int                              pending_count,
   output int                              checked_count,
   output int                              square_count,
   output int                              sieve_only_count
);
   import bpst_pkg::*;

   localparam int unsigned SIEVE_MODULI [4] = '{64, 63, 65, 187};

   typedef struct packed {
      logic                  filter_ok;
      logic                  is_square;
      logic [BOUND_BITS-1:0] root;
   } verdict_type;

   verdict_type           expected_verdicts [$];
   logic [BOUND_BITS-1:0] bound_copy;

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] acc;
      logic [63:0] trial;
      acc = '0;
      for (int i = SQ_BITS - 1; i >= 0; i--) begin
         trial = acc | (64'd1 << i);
         if (trial * trial <= v) acc = trial;
      end
      return acc;
   endfunction

   function automatic bit is_residue(input logic [63:0] v, input int unsigned m);
      int unsigned rem;
      rem = 32'(v % 64'(m));
      for (int unsigned x = 0; x < m; x++) begin
         if ((x * x) % m == rem) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic verdict_type predict_verdict(input logic [VALUE_BITS-1:0] value,
                                                   input logic [BOUND_BITS-1:0] bound);
      verdict_type vd;
      logic [63:0] v;
      logic [63:0] r;
      v = 64'(value);
      r = floor_root(v);
      vd.filter_ok = 1'b1;
      foreach (SIEVE_MODULI[j]) begin
         if (!is_residue(v, SIEVE_MODULI[j])) vd.filter_ok = 1'b0;
      end
      vd.is_square = (r * r == v) && (r <= 64'(bound));
      vd.root      = vd.is_square ? r[BOUND_BITS-1:0] : '0;
      return vd;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         bound_copy = BOUND_RESET;
         expected_verdicts.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     predict_verdict(req_value, bound_copy));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, actual pass=%b square=%b root=%0d",
                        $time, rsp_filter_ok, rsp_is_square, rsp_root);
            end else begin
               want = expected_verdicts.pop_front();
               checked_count++;
               if (want.is_square) square_count++;
               if (want.filter_ok && !want.is_square) sieve_only_count++;
               if (rsp_filter_ok !== want.filter_ok) begin
                  fail_count++;
                  $display("%0t: filter_ok mismatch, expected %b, actual %b",
                           $time, want.filter_ok, rsp_filter_ok);
               end
               if (rsp_is_square !== want.is_square) begin
                  fail_count++;
                  $display("%0t: is_square mismatch, expected %b, actual %b",
                           $time, want.is_square, rsp_is_square);
               end
               if (rsp_root !== want.root) begin
                  fail_count++;
                  $display("%0t: root mismatch, expected %0d, actual %0d",
                           $time, want.root, rsp_root);
               end
            end
         end
         if (csr_write_enable) bound_copy = csr_write_data;
      end
      pending_count = expected_verdicts.size();
   end

endmodule

### tb/bounded_perfect_square_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_perfect_square_test_unit_tb
// Drives the square test unit with directed edge values and then biased
// random words (squares near the bound, near-squares, words that pass the
// residue sieve without being square, raw values) across several root bound
// settings, with bursty requests, a stalling receiver and two long hold-offs.
// The checker beside the unit predicts and compares every response word.
// ----------------------------------------------------------------------------
module bounded_perfect_square_test_unit_tb;
   import bpst_pkg::*;

   localparam int      LIMIT_CYCLES    = 500000;
   localparam int      PHASES          = 8;
   localparam int      WORDS_PER_PHASE = 200;
   localparam int      HOLD_CYCLES     = 300;
   localparam int      TAIL_CYCLES     = 40;
   localparam longint  SIEVE_PERIOD    = 64 * 63 * 65 * 187;
   localparam logic [BOUND_BITS-1:0] BOUND_TOP = '1;

   localparam logic [VALUE_BITS-1:0] DIRECTED_VALUES [25] = '{
      60'd0, 60'd1, 60'd2, 60'd3, 60'd4, {VALUE_BITS{1'b1}},
      60'hFFFFFFF80000001, 60'hFFFFFFF80000000,
      60'd1440000, 60'd1442401, 60'd1437601, 60'd1440001, 60'd1439999,
      60'd49008960, 60'd49008961, 60'd1 << 58, 60'd1 << 59,
      60'hAAAAAAAAAAAAAAA, 60'h555555555555555,
      60'd144, 60'd63, 60'd64, 60'd65, 60'd187, 60'd36
   };

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value        = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic                  rsp_filter_ok;
   logic                  rsp_is_square;
   logic [BOUND_BITS-1:0] rsp_root;
   logic                  csr_write_enable = 1'b0;
   logic [BOUND_BITS-1:0] csr_write_data   = '0;

   int                    fail_count;
   int                    pending_count;
   int                    checked_count;
   int                    square_count;
   int                    sieve_only_count;

   logic [BOUND_BITS-1:0] cur_bound    = BOUND_RESET;
   int                    cycle_count  = 0;
   int                    burst_left   = 0;
   int                    words_sent   = 0;
   int                    bounds_tried = 1;
   bit                    hold_request = 1'b0;
   int                    hold_count   = 0;

   bounded_perfect_square_test_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filter_ok    (rsp_filter_ok),
      .rsp_is_square    (rsp_is_square),
      .rsp_root         (rsp_root),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   bounded_perfect_square_test_unit_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filter_ok    (rsp_filter_ok),
      .rsp_is_square    (rsp_is_square),
      .rsp_root         (rsp_root),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .square_count     (square_count),
      .sieve_only_count (sieve_only_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // offer a word; when the current burst is used up, start a new one, mostly after a random idle gap
   task automatic send_word(input logic [VALUE_BITS-1:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   task automatic write_bound(input logic [BOUND_BITS-1:0] b);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= b;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_bound = b;
      bounds_tried++;
   endtask

   function automatic logic [63:0] pick_root();
      int unsigned w;
      w = $urandom_range(1, BOUND_BITS);
      return 64'($urandom & ((32'd1 << w) - 1));
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      int unsigned kind;
      int unsigned w;
      longint      near;
      logic [63:0] r;
      logic [63:0] v;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         near = longint'(cur_bound) + int'($urandom_range(0, 6)) - 3;
         if (near < 0) near = 0;
         if (near > longint'(BOUND_TOP)) near = longint'(BOUND_TOP);
         r = 64'(near);
         v = r * r;
      end else if (kind < 30) begin
         r = pick_root();
         v = r * r;
      end else if (kind < 42) begin
         r = pick_root();
         v = r * r + 64'(int'($urandom_range(0, 3)) - 2);
         if (v == r * r) v = v + 64'd1;
      end else if (kind < 57) begin
         r = pick_root();
         v = r * r + 64'(SIEVE_PERIOD) * 64'($urandom_range(1, 1000));
      end else if (kind < 80) begin
         v = {$urandom, $urandom};
      end else if (kind < 90) begin
         v = 64'($urandom_range(0, 2000));
      end else begin
         w = $urandom_range(1, VALUE_BITS);
         v = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
      end
      return v[VALUE_BITS-1:0];
   endfunction

   // receiver: ready patterns of varying density, and a long hold-off on request
   initial begin
      int mode;
      int span;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            hold_count++;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            for (int i = 0; i < span && !hold_request; i++) begin
               case (mode)
                  0: begin
                     rsp_ready <= 1'b1;
                  end
                  1: begin
                     rsp_ready <= 1'($urandom_range(0, 1));
                  end
                  2: begin
                     rsp_ready <= ($urandom_range(0, 3) == 0);
                  end
                  default: begin
                     rsp_ready <= (i % 3 == 0);
                  end
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_VALUES[i]) send_word(DIRECTED_VALUES[i]);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: ;
            1: write_bound(BOUND_BITS'(1));
            2: write_bound('0);
            3: write_bound(BOUND_TOP);
            4: write_bound(BOUND_BITS'($urandom_range(1, 1000000000)));
            5: write_bound(BOUND_BITS'(1000000000));
            6: write_bound(BOUND_BITS'($urandom_range(1, 5000)));
            default: write_bound(BOUND_BITS'($urandom));
         endcase
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ((p == 0 || p == 5) && n == 50) hold_request = 1'b1;
            if (p == 4 && n == 100) drain_results();
            send_word(pick_value());
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d words over %0d bound settings with %0d long hold-offs",
               words_sent, bounds_tried, hold_count);
      $display("checked %0d results: %0d accepted squares, %0d sieve passes not square",
               checked_count, square_count, sieve_only_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/bpst_pkg.sv
hw/rtl/bpst_front.sv
hw/rtl/bpst_queue.sv
hw/rtl/bpst_root.sv
hw/rtl/bounded_perfect_square_test_unit.sv
tb/bounded_perfect_square_test_unit_checker.sv
tb/bounded_perfect_square_test_unit_tb.sv
